// ===== hw/rtl/fpr_pkg.sv =====
// shared types and constants for the fifo page replacement block
package fpr_pkg;

   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;

   localparam int PAGE_NUM_W = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int COUNT_W    = 16;
   localparam int CSR_W      = 5;

   localparam logic [CSR_W-1:0]   ACTIVE_RESET = 5'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   typedef struct packed {
      logic valid;
      logic hit;
      logic ev_valid;
   } token_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/fpr_req_if.sv =====
// request channel carrying one page reference per transfer
interface fpr_req_if
   import fpr_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [PAGE_NUM_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

// ===== hw/rtl/fpr_rsp_if.sv =====
// response channel carrying one lookup result per transfer
interface fpr_rsp_if
   import fpr_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic                  page_fault;
   logic [SLOT_OUT_W-1:0] slot_used;
   logic                  evicted_valid;
   logic [PAGE_NUM_W-1:0] evicted_page;
   logic [COUNT_W-1:0]    fault_total;

   modport source (output valid, output page_fault, output slot_used, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input page_fault, input slot_used, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

// ===== hw/rtl/fpr_cell.sv =====
// one page frame cell: holds a frame, checks the passing probe, forwards it
module fpr_cell
   import fpr_pkg::*;
#(
   parameter int PAGE_W = 16,
   parameter int SLOT_W = 4,
   parameter int CNT_W  = 5,
   parameter int INDEX  = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [PAGE_W-1:0] wr_page,
   input  logic [SLOT_W-1:0] oldest,
   input  logic [CNT_W-1:0]  frames,
   input  token_ctrl_type    in_ctrl,
   input  logic [PAGE_W-1:0] in_page,
   input  logic [SLOT_W-1:0] in_slot,
   input  logic [PAGE_W-1:0] in_ev_page,
   output token_ctrl_type    out_ctrl,
   output logic [PAGE_W-1:0] out_page,
   output logic [SLOT_W-1:0] out_slot,
   output logic [PAGE_W-1:0] out_ev_page
);

   localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(INDEX);
   localparam logic [CNT_W-1:0]  MY_COUNT = CNT_W'(INDEX);

   logic              valid_ff, valid_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   token_ctrl_type    ctrl_ff, ctrl_in;
   logic [PAGE_W-1:0] tok_page_ff;
   logic [SLOT_W-1:0] tok_slot_ff, tok_slot_in;
   logic [PAGE_W-1:0] tok_ev_ff, tok_ev_in;

   logic active;
   logic match;
   logic is_oldest;

   assign active    = MY_COUNT < frames;
   assign match     = in_ctrl.valid && !in_ctrl.hit && active && valid_ff && (page_ff == in_page);
   assign is_oldest = in_ctrl.valid && (oldest == MY_SLOT);

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (wr_en && (oldest == MY_SLOT)) begin
         valid_in = 1'b1;
         page_in  = wr_page;
      end
   end

   always_comb begin
      ctrl_in     = in_ctrl;
      tok_slot_in = in_slot;
      tok_ev_in   = in_ev_page;
      if (match) begin
         ctrl_in.hit = 1'b1;
         tok_slot_in = MY_SLOT;
      end
      if (is_oldest) begin
         ctrl_in.ev_valid = valid_ff;
         tok_ev_in        = valid_ff ? page_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctrl_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         ctrl_ff  <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      tok_page_ff <= in_page;
      tok_slot_ff <= tok_slot_in;
      tok_ev_ff   <= tok_ev_in;
   end

   assign out_ctrl    = ctrl_ff;
   assign out_page    = tok_page_ff;
   assign out_slot    = tok_slot_ff;
   assign out_ev_page = tok_ev_ff;

endmodule

// ===== hw/rtl/fifo_page_replacement.sv =====
// fifo page replacement: a lookup probe walks a chain of frame cells, one per cycle
// a probe passes each frame cell register, then the finish and response registers
// one reference at a time: a new request is taken once the last is in the output register
// a finished response waits in its output register while the next request is taken
// reset: synchronous, clears frames, oldest pointer and fault count, frame count to 3
module fifo_page_replacement
   import fpr_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   fpr_req_if.sink          req,
   fpr_rsp_if.source        rsp,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int PAGE_W = (PAGE_BITS < PAGE_NUM_W) ? PAGE_BITS : PAGE_NUM_W;
   localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

   function automatic logic [CNT_W-1:0] clamp_frames(input logic [CSR_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (int'(v) > MAX_FRAMES) begin
         r = CNT_W'(MAX_FRAMES);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  frames_ff, frames_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   token_ctrl_type    fin_ctrl_ff, fin_ctrl_in;
   logic [PAGE_W-1:0] fin_page_ff, fin_page_in;
   logic [SLOT_W-1:0] fin_slot_ff, fin_slot_in;
   logic [PAGE_W-1:0] fin_ev_ff, fin_ev_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fault_ff, rsp_fault_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_NUM_W-1:0] rsp_ev_page_ff, rsp_ev_page_in;
   logic [COUNT_W-1:0]    rsp_total_ff, rsp_total_in;

   token_ctrl_type    chain_ctrl    [MAX_FRAMES+1];
   logic [PAGE_W-1:0] chain_page    [MAX_FRAMES+1];
   logic [SLOT_W-1:0] chain_slot    [MAX_FRAMES+1];
   logic [PAGE_W-1:0] chain_ev_page [MAX_FRAMES+1];

   logic              req_accept;
   logic              out_free;
   logic              wr_en;
   logic [CNT_W-1:0]  oldest_next;
   logic [SLOT_W-1:0] slot_sel;
   logic [31:0]       slot_wide;

   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   assign chain_ctrl[0]    = '{valid: req_accept, hit: 1'b0, ev_valid: 1'b0};
   assign chain_page[0]    = req.page_number[PAGE_W-1:0];
   assign chain_slot[0]    = '0;
   assign chain_ev_page[0] = '0;

   for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
      fpr_cell #(
         .PAGE_W (PAGE_W),
         .SLOT_W (SLOT_W),
         .CNT_W  (CNT_W),
         .INDEX  (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .clear       (csr_wr_en),
         .wr_en       (wr_en),
         .wr_page     (fin_page_ff),
         .oldest      (oldest_ff),
         .frames      (frames_ff),
         .in_ctrl     (chain_ctrl[k]),
         .in_page     (chain_page[k]),
         .in_slot     (chain_slot[k]),
         .in_ev_page  (chain_ev_page[k]),
         .out_ctrl    (chain_ctrl[k+1]),
         .out_page    (chain_page[k+1]),
         .out_slot    (chain_slot[k+1]),
         .out_ev_page (chain_ev_page[k+1])
      );
   end

   assign oldest_next = CNT_W'(oldest_ff) + CNT_W'(1);
   assign slot_sel    = fin_ctrl_ff.hit ? fin_slot_ff : oldest_ff;
   assign slot_wide   = 32'(slot_sel);

   always_comb begin
      state_in        = state_ff;
      frames_in       = frames_ff;
      oldest_in       = oldest_ff;
      count_in        = count_ff;
      fin_ctrl_in     = fin_ctrl_ff;
      fin_page_in     = fin_page_ff;
      fin_slot_in     = fin_slot_ff;
      fin_ev_in       = fin_ev_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_fault_in    = rsp_fault_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_total_in    = rsp_total_ff;
      wr_en           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (chain_ctrl[MAX_FRAMES].valid) begin
               fin_ctrl_in = chain_ctrl[MAX_FRAMES];
               fin_page_in = chain_page[MAX_FRAMES];
               fin_slot_in = chain_slot[MAX_FRAMES];
               fin_ev_in   = chain_ev_page[MAX_FRAMES];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               if (!fin_ctrl_ff.hit) begin
                  wr_en     = 1'b1;
                  oldest_in = (oldest_next >= frames_ff) ? '0 : SLOT_W'(oldest_next);
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               rsp_valid_in    = 1'b1;
               rsp_fault_in    = !fin_ctrl_ff.hit;
               rsp_slot_in     = slot_wide[SLOT_OUT_W-1:0];
               rsp_ev_valid_in = !fin_ctrl_ff.hit && fin_ctrl_ff.ev_valid;
               rsp_ev_page_in  = (!fin_ctrl_ff.hit && fin_ctrl_ff.ev_valid) ?
                                 PAGE_NUM_W'(fin_ev_ff) : '0;
               rsp_total_in    = count_in;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         frames_in = clamp_frames(csr_wr_data);
         oldest_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= clamp_frames(ACTIVE_RESET);
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ctrl_ff     <= fin_ctrl_in;
      fin_page_ff     <= fin_page_in;
      fin_slot_ff     <= fin_slot_in;
      fin_ev_ff       <= fin_ev_in;
      rsp_fault_ff    <= rsp_fault_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_total_ff    <= rsp_total_in;
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.page_fault    = rsp_fault_ff;
   assign rsp.slot_used     = rsp_slot_ff;
   assign rsp.evicted_valid = rsp_ev_valid_ff;
   assign rsp.evicted_page  = rsp_ev_page_ff;
   assign rsp.fault_total   = rsp_total_ff;

endmodule

// ===== hw/rtl/fpr_checker.sv =====
// port level checks for the fifo page replacement block, bound to the top level
module fpr_checker
   import fpr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  page_fault,
   input logic [SLOT_OUT_W-1:0] slot_used,
   input logic                  evicted_valid,
   input logic [PAGE_NUM_W-1:0] evicted_page,
   input logic [COUNT_W-1:0]    fault_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(page_fault) && $stable(slot_used)
         && $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_total))
      else $error("response changed while stalled");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !page_fault |-> !evicted_valid)
      else $error("eviction reported on a hit");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !evicted_valid |-> (evicted_page == '0))
      else $error("evicted page not zero without eviction");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a lookup is in flight");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .page_fault    (rsp.page_fault),
   .slot_used     (rsp.slot_used),
   .evicted_valid (rsp.evicted_valid),
   .evicted_page  (rsp.evicted_page),
   .fault_total   (rsp.fault_total)
);

// ===== bench/tb_top.sv =====
// testbench for fifo_page_replacement: directed and random references checked against a predictor
`timescale 1ns / 100ps

module tb_top;
   import fpr_pkg::*;

   localparam int SETTLE_CYCLES = 2 * (MAX_FRAMES_DEF + 1);
   localparam int STALL_LIMIT   = 4000;
   localparam int POOL_SIZE     = 24;

   typedef struct packed {
      logic                  fault;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  ev_valid;
      logic [PAGE_NUM_W-1:0] ev_page;
      logic [COUNT_W-1:0]    total;
   } lookup_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   fpr_req_if req_ch ();
   fpr_rsp_if rsp_ch ();

   fifo_page_replacement dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [PAGE_NUM_W-1:0] resident_page  [MAX_FRAMES_DEF];
   logic                  resident_valid [MAX_FRAMES_DEF];
   int                    oldest_ptr;
   logic [COUNT_W-1:0]    fault_tally;
   logic [CSR_W-1:0]      frame_setting;

   lookup_type expected_lookups[$];
   int      mismatches = 0;
   int      req_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      quiet_cycles = 0;

   always #4 clock = ~clock;

   function automatic int frames_in_effect(input logic [CSR_W-1:0] setting);
      int n;
      n = int'(setting);
      if (n < 1) n = 1;
      if (n > MAX_FRAMES_DEF) n = MAX_FRAMES_DEF;
      return n;
   endfunction

   function automatic void clear_frames(input logic [CSR_W-1:0] setting);
      for (int k = 0; k < MAX_FRAMES_DEF; k++) begin
         resident_page[k]  = '0;
         resident_valid[k] = 1'b0;
      end
      oldest_ptr    = 0;
      fault_tally   = '0;
      frame_setting = setting;
   endfunction

   function automatic lookup_type fifo_lookup(input logic [PAGE_NUM_W-1:0] pg);
      lookup_type r;
      int      n;
      logic    hit;
      r   = '0;
      hit = 1'b0;
      n   = frames_in_effect(frame_setting);
      for (int k = 0; k < n; k++) begin
         if (!hit && resident_valid[k] && resident_page[k] == pg) begin
            hit    = 1'b1;
            r.slot = SLOT_OUT_W'(k);
         end
      end
      if (!hit) begin
         if (oldest_ptr >= n) oldest_ptr = 0;
         r.slot = SLOT_OUT_W'(oldest_ptr);
         if (resident_valid[oldest_ptr]) begin
            r.ev_valid = 1'b1;
            r.ev_page  = resident_page[oldest_ptr];
         end
         resident_page[oldest_ptr]  = pg;
         resident_valid[oldest_ptr] = 1'b1;
         oldest_ptr = (oldest_ptr + 1 >= n) ? 0 : oldest_ptr + 1;
         if (fault_tally != COUNT_MAX) fault_tally = fault_tally + 1'b1;
      end
      r.fault = !hit;
      r.total = fault_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_page(input logic [PAGE_NUM_W-1:0] pg);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.page_number <= pg;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      expected_lookups.insert(expected_lookups.size(), fifo_lookup(pg));
      @(negedge clock);
   endtask

   task automatic drain_lookups();
      req_ch.valid <= 1'b0;
      while (expected_lookups.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frames(input logic [CSR_W-1:0] setting);
      drain_lookups();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      clear_frames(setting);
   endtask

   task automatic set_pacing(input int req_pct, input int rsp_pct);
      req_idle_pct  = req_pct;
      rsp_stall_pct = rsp_pct;
   endtask

   task automatic test_reset_state();
      send_page(16'h0000);
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h1234);
      send_page(16'h8000);
      send_page(16'h0000);
      send_page(16'hFFFF);
   endtask

   task automatic test_frame_count_limits();
      write_frames(5'd0);
      send_page(16'h0005);
      send_page(16'h0005);
      send_page(16'h0000);
      send_page(16'h0000);
      write_frames(5'd31);
      send_page(16'hAAAA);
      send_page(16'h5555);
      send_page(16'hAAAA);
      send_page(16'h0000);
      write_frames(5'd16);
      send_page(16'h7FFF);
      send_page(16'h7FFF);
   endtask

   task automatic test_random_traffic();
      int               req_pcts [4] = '{0, 68, 0, 16};
      int               rsp_pcts [4] = '{0, 0, 68, 16};
      logic [CSR_W-1:0] settings [12];
      logic [PAGE_NUM_W-1:0] pool [POOL_SIZE];
      int               pool_lim;
      int               pick;
      settings = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8,
                   5'd17, 5'd2, CSR_W'($urandom_range(31)),
                   5'd3, 5'd12, CSR_W'($urandom_range(31))};
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 3; s++) begin
            write_frames(settings[p * 3 + s]);
            set_pacing(req_pcts[p], rsp_pcts[p]);
            for (int i = 0; i < POOL_SIZE; i++) pool[i] = PAGE_NUM_W'($urandom);
            pool_lim = frames_in_effect(settings[p * 3 + s]) + 1 + $urandom_range(4);
            if (pool_lim > POOL_SIZE) pool_lim = POOL_SIZE;
            for (int i = 0; i < 108; i++) begin
               pick = $urandom_range(99);
               if (pick < 70)
                  send_page(pool[$urandom_range(pool_lim - 1)]);
               else if (pick < 90)
                  send_page(PAGE_NUM_W'($urandom));
               else
                  send_page($urandom_range(1) ? 16'hFFFF : 16'h0000);
            end
         end
      end
   endtask

   // one frame and alternating pages: every reference faults, and every one after the first evicts
   task automatic test_fault_streak();
      set_pacing(0, 0);
      write_frames(5'd1);
      for (int i = 0; i < 40; i++) send_page(i[0] ? 16'h00A5 : 16'h005A);
      send_page(16'h005A);
      send_page(16'h0000);
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_lookups
      lookup_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(rsp_ch.slot_used), '0);
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_ch.page_fault !== want.fault)
               report_mismatch("page_fault", 32'(rsp_ch.page_fault), 32'(want.fault));
            if (rsp_ch.slot_used !== want.slot)
               report_mismatch("slot_used", 32'(rsp_ch.slot_used), 32'(want.slot));
            if (rsp_ch.evicted_valid !== want.ev_valid)
               report_mismatch("evicted_valid", 32'(rsp_ch.evicted_valid),
                               32'(want.ev_valid));
            if (rsp_ch.evicted_page !== want.ev_page)
               report_mismatch("evicted_page", 32'(rsp_ch.evicted_page), 32'(want.ev_page));
            if (rsp_ch.fault_total !== want.total)
               report_mismatch("fault_total", 32'(rsp_ch.fault_total), 32'(want.total));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[fifo_page_replacement] ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.page_number = '0;
      rsp_ch.ready       = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      clear_frames(ACTIVE_RESET);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_frame_count_limits();
      test_random_traffic();
      test_fault_streak();
      drain_lookups();
      if (mismatches == 0)
         $display("[fifo_page_replacement] OK");
      else
         $display("[fifo_page_replacement] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_req_if.sv
hw/rtl/fpr_rsp_if.sv
hw/rtl/fpr_cell.sv
hw/rtl/fifo_page_replacement.sv
hw/rtl/fpr_checker.sv
bench/tb_top.sv
